[src/sfcc_pkg.sv]
`default_nettype none

package sfcc_pkg;

    // CRC-8 parameters of the sensor reply
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Frame layout: byte positions within one reply
    localparam logic [2:0] POS_TEMP_MSB = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_MSB  = 3'd3;
    localparam logic [2:0] POS_HUM_LSB  = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // Conversion constants (hundredths)
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [13:0] HUM_MAX     = 14'd10000;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_ERR = 2'd1,
        STATUS_HUM_ERR  = 2'd2
    } status_t;

    // One completed frame handed from the byte tracker to the converter
    typedef struct packed {
        status_t     status;
        logic [15:0] temp_code;
        logic [15:0] hum_raw;
    } frame_t;

endpackage

`default_nettype wire

[src/sensor_frame_crc_check_convert_core.sv]
// Sensor reply frame checker and converter.
// Input channel (in_valid / in_stall, rx_byte, frame_start) takes one reply
// byte per transfer: temperature MSB, LSB, CRC, humidity MSB, LSB, CRC.
// frame_start marks the first byte and restarts the count; without it the
// count wraps after the sixth byte. Each word is checked with CRC-8 (0x31,
// init 0xFF). The sixth byte yields one transfer on the output channel
// (out_valid / out_stall): status, raw words, temperature and humidity
// in hundredths. All other bytes yield nothing.
// Throughput: one byte per cycle while in_stall is low. The result of the sixth
// byte passes frame capture at the edge that takes it, the multiply stage and
// the divide correction into the output register.
// When out_stall holds, results queue in the three stages; in_stall rises
// only when all three are full, and the output payload holds steady.
// Reset clears the byte count, CRC and word state and empties the pipeline.
`default_nettype none

module sensor_frame_crc_check_convert_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               frame_start,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [15:0]             temp_code,
    output logic [15:0]             hum_raw,
    output logic signed [14:0]      temp_centi,
    output logic [13:0]             hum_centi
);

    logic             accept;
    logic             done;
    logic             conv_ready;
    sfcc_pkg::frame_t frame;

    assign in_stall = !conv_ready;
    assign accept   = in_valid && conv_ready;

    // Byte tracking and CRC check
    sfcc_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .done        (done),
        .frame       (frame)
    );

    // Fixed-point conversion pipeline
    sfcc_convert u_convert
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && done),
        .frame      (frame),
        .ready      (conv_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .temp_code  (temp_code),
        .hum_raw    (hum_raw),
        .temp_centi (temp_centi),
        .hum_centi  (hum_centi)
    );

endmodule

`default_nettype wire

[src/sfcc_frame.sv]
`default_nettype none

module sfcc_frame
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             frame_start,
    output logic                  done,
    output sfcc_pkg::frame_t      frame
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_reg, temp_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [7:0]  hum_lo_reg, hum_lo_next;
    logic        temp_ok_reg, temp_ok_next;
    logic [2:0]  eff_pos;

    // Bitwise CRC-8, MSB first, fully unrolled over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ sfcc_pkg::CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Frame start or an out-of-range count restarts at the first byte
    assign eff_pos = (frame_start || pos_reg > sfcc_pkg::POS_HUM_CRC) ?
                     sfcc_pkg::POS_TEMP_MSB : pos_reg;

    // Byte tracking and CRC update
    always_comb
    begin
        crc_next     = crc_reg;
        temp_next    = temp_reg;
        hum_hi_next  = hum_hi_reg;
        hum_lo_next  = hum_lo_reg;
        temp_ok_next = temp_ok_reg;
        pos_next     = eff_pos + 3'd1;
        done         = 1'b0;
        unique case (eff_pos)
            sfcc_pkg::POS_TEMP_MSB:
            begin
                temp_next = {rx_byte, 8'h00};
                crc_next  = crc8_byte(sfcc_pkg::CRC_INIT, rx_byte);
            end
            sfcc_pkg::POS_TEMP_LSB:
            begin
                temp_next = {temp_reg[15:8], rx_byte};
                crc_next  = crc8_byte(crc_reg, rx_byte);
            end
            sfcc_pkg::POS_TEMP_CRC:
            begin
                temp_ok_next = (crc_reg == rx_byte);
                crc_next     = sfcc_pkg::CRC_INIT;
            end
            sfcc_pkg::POS_HUM_MSB:
            begin
                hum_hi_next = rx_byte;
                crc_next    = crc8_byte(sfcc_pkg::CRC_INIT, rx_byte);
            end
            sfcc_pkg::POS_HUM_LSB:
            begin
                hum_lo_next = rx_byte;
                crc_next    = crc8_byte(crc_reg, rx_byte);
            end
            default:
            begin
                // last byte: frame complete
                done     = 1'b1;
                pos_next = sfcc_pkg::POS_TEMP_MSB;
                crc_next = sfcc_pkg::CRC_INIT;
            end
        endcase
    end

    // Completed frame; temperature error wins over humidity error
    always_comb
    begin
        frame.temp_code = temp_reg;
        frame.hum_raw   = {hum_hi_reg, hum_lo_reg};
        if (!temp_ok_reg)
            frame.status = sfcc_pkg::STATUS_TEMP_ERR;
        else if (crc_reg != rx_byte)
            frame.status = sfcc_pkg::STATUS_HUM_ERR;
        else
            frame.status = sfcc_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= sfcc_pkg::POS_TEMP_MSB;
            crc_reg     <= sfcc_pkg::CRC_INIT;
            temp_reg    <= '0;
            hum_hi_reg  <= '0;
            hum_lo_reg  <= '0;
            temp_ok_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            temp_reg    <= temp_next;
            hum_hi_reg  <= hum_hi_next;
            hum_lo_reg  <= hum_lo_next;
            temp_ok_reg <= temp_ok_next;
        end
    end

endmodule

`default_nettype wire

[src/sfcc_convert.sv]
`default_nettype none

module sfcc_convert
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire sfcc_pkg::frame_t    frame,
    output logic                     ready,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               status,
    output logic [15:0]              temp_code,
    output logic [15:0]              hum_raw,
    output logic signed [14:0]       temp_centi,
    output logic [13:0]              hum_centi
);

    // Stage 1: frame fields
    logic              s1_valid_reg;
    sfcc_pkg::frame_t  s1_frame_reg;
    // Stage 2: scaled products
    logic              s2_valid_reg;
    sfcc_pkg::frame_t  s2_frame_reg;
    logic [30:0]       t_prod_reg;
    logic [29:0]       h_prod_reg;
    // Output register
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [15:0]       temp_code_reg;
    logic [15:0]       hum_raw_reg;
    logic [14:0]       temp_centi_reg;
    logic [13:0]       hum_centi_reg;

    logic              out_ready, s2_ready, s1_ready;
    logic [15:0]       t_quot, h_quot;
    logic [15:0]       t_signed;
    logic [13:0]       h_clamped;

    // floor(x / 65535): x>>16 is at most one short; remainder check fixes it
    function automatic logic [15:0] div65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r0;
        q0 = x[30:16];
        r0 = {1'b0, x[15:0]} + {2'b00, q0};
        return {1'b0, q0} + ((r0 >= 17'd65535) ? 16'd1 : 16'd0);
    endfunction

    // Pipeline flow control
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign ready     = s1_ready;

    // Division correction, offset and clamp
    always_comb
    begin
        t_quot    = div65535(t_prod_reg);
        h_quot    = div65535({1'b0, h_prod_reg});
        t_signed  = t_quot - sfcc_pkg::TEMP_OFFSET;
        h_clamped = (h_quot > {2'b00, sfcc_pkg::HUM_MAX}) ? sfcc_pkg::HUM_MAX : h_quot[13:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= load;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (s1_ready && load)
            s1_frame_reg <= frame;
        if (s2_ready && s1_valid_reg)
        begin
            s2_frame_reg <= s1_frame_reg;
            t_prod_reg   <= sfcc_pkg::TEMP_SPAN * s1_frame_reg.temp_code;
            h_prod_reg   <= sfcc_pkg::HUM_SPAN * s1_frame_reg.hum_raw;
        end
        if (out_ready && s2_valid_reg)
        begin
            status_reg     <= s2_frame_reg.status;
            temp_code_reg  <= s2_frame_reg.temp_code;
            hum_raw_reg    <= s2_frame_reg.hum_raw;
            temp_centi_reg <= t_signed[14:0];
            hum_centi_reg  <= h_clamped;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign temp_code  = temp_code_reg;
    assign hum_raw    = hum_raw_reg;
    assign temp_centi = $signed(temp_centi_reg);
    assign hum_centi  = hum_centi_reg;

endmodule

`default_nettype wire

[src/sfcc_checker.sv]
`default_nettype none

module sfcc_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic [15:0]        temp_code,
    input wire logic [13:0]        hum_centi
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its raw temperature word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(temp_code))
        else $error("result changed while stalled");

    // Status code is one of the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == sfcc_pkg::STATUS_OK || status == sfcc_pkg::STATUS_TEMP_ERR
                       || status == sfcc_pkg::STATUS_HUM_ERR))
        else $error("illegal status code");

    // Humidity stays within the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hum_centi <= sfcc_pkg::HUM_MAX)
        else $error("humidity above full scale");

    // Input is never held off while the output side has room and is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && $past(!out_valid, 2) && $past(!in_valid)
        && $past(!in_valid, 2) && $past(!in_valid, 3) |-> !in_stall)
        else $error("input stalled with empty pipeline");

endmodule

bind sensor_frame_crc_check_convert_core sfcc_checker u_sfcc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .temp_code (temp_code),
    .hum_centi (hum_centi)
);

`default_nettype wire
